/* sv/vhiu_pkg.sv */
// Shared types and codes for the versioned hash index upsert unit.
// No dependencies; imported by versioned_hash_index_upsert_unit.
`default_nettype none

package vhiu_pkg;

    // Field widths fixed by the item format
    localparam int WORD_W   = 64;
    localparam int KEY_W    = 4 * WORD_W;
    localparam int LIMIT_W  = 11;
    localparam int STATUS_W = 3;

    // Reset value of the probe limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // Command codes carried in s_tuser
    localparam logic CMD_UPSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result status codes carried in m_tuser
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd5;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] memo;
        logic [WORD_W-1:0] slot;
        logic [WORD_W-1:0] location;
    } entry_t;

endpackage

`default_nettype wire

/* sv/versioned_hash_index_upsert_unit.sv */
// Linear-probing hash index with versioned upsert and lookup.
// Depends on vhiu_pkg (entry type, command and status codes).
//
//  Channel  | Signals                                   | Moves
//  ---------+-------------------------------------------+-----------------------------
//  s_*      | s_tvalid s_tready s_tdata s_tuser         | command item in
//  m_*      | m_tvalid m_tready m_tdata m_tuser         | one result item per command
//  cfg_*    | cfg_valid cfg_ready cfg_data              | probe_limit write
//
// One item is worked at a time. Each probe passes S_READ, one read of the
// single-port entry memory, then S_CHECK, a compare/write-back step; S_DONE
// then loads the result register, and only after that is a new item accepted.
// After reset a clearing pass writes every entry invalid, with s_tready low.
// The result register lets a new item enter while m_* stalls.
`default_nettype none

module versioned_hash_index_upsert_unit #(
    parameter int TABLE_DEPTH = 1024  // power of two, 2 to 1048576
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // slave side
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // key_word_0, key_word_1, key_word_2, key_word_3, hash_memo,
    // record_slot, record_location (64 bits each, low to high)
    input  wire  [7*vhiu_pkg::WORD_W-1:0]    s_tdata,
    // command
    input  wire                              s_tuser,
    // master side
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // found_location, found_slot (64 bits each, low to high)
    output logic [2*vhiu_pkg::WORD_W-1:0]    m_tdata,
    // status
    output logic [vhiu_pkg::STATUS_W-1:0]    m_tuser,
    // configuration
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [vhiu_pkg::LIMIT_W-1:0]     cfg_data
);
    import vhiu_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = (IDX_W + 1 > LIMIT_W) ? IDX_W + 1 : LIMIT_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);

    // Controller states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Control registers
    logic [2:0]          state_reg,    state_next;
    logic [LIMIT_W-1:0]  limit_reg,    limit_next;
    logic [IDX_W-1:0]    idx_reg,      idx_next;
    logic [CNT_W-1:0]    left_reg,     left_next;
    logic                m_valid_reg,  m_valid_next;

    // Payload registers
    logic                cmd_reg,      cmd_next;
    logic [KEY_W-1:0]    key_reg,      key_next;
    logic [WORD_W-1:0]   memo_reg,     memo_next;
    logic [WORD_W-1:0]   slot_reg,     slot_next;
    logic [WORD_W-1:0]   loc_reg,      loc_next;
    logic [STATUS_W-1:0] res_st_reg,   res_st_next;
    logic [WORD_W-1:0]   res_loc_reg,  res_loc_next;
    logic [WORD_W-1:0]   res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0] m_user_reg,   m_user_next;
    logic [2*WORD_W-1:0] m_data_reg,   m_data_next;

    // Entry memory
    entry_t              entry_mem [TABLE_DEPTH];
    entry_t              rd_entry;
    entry_t              wr_entry;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;

    logic [CNT_W-1:0]    limit_ext;
    logic [CNT_W-1:0]    left_init;
    logic                accept;
    logic                hit;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // Clamp the probe length to the table size
    assign limit_ext = CNT_W'(limit_reg);
    assign left_init = (limit_ext > DEPTH_CNT) ? DEPTH_CNT : limit_ext;

    // Stop at a free entry or at a matching memo and key
    assign hit = !rd_entry.valid ||
                 (rd_entry.memo == memo_reg && rd_entry.key == key_reg);

    // Read one entry a cycle; write back during the check or clearing pass
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_entry <= entry_mem[idx_reg];
    end

    // Next-state and datapath logic
    always_comb
    begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        m_valid_next  = m_valid_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        memo_next     = memo_reg;
        slot_next     = slot_reg;
        loc_next      = loc_reg;
        res_st_next   = res_st_reg;
        res_loc_next  = res_loc_reg;
        res_slot_next = res_slot_reg;
        m_user_next   = m_user_reg;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_entry      = '0;

        // Take configuration writes at any time
        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Mark every entry free, one per cycle
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = s_tuser;
                    key_next  = s_tdata[KEY_W-1:0];
                    memo_next = s_tdata[KEY_W +: WORD_W];
                    slot_next = s_tdata[KEY_W+WORD_W +: WORD_W];
                    loc_next  = s_tdata[KEY_W+2*WORD_W +: WORD_W];
                    idx_next  = s_tdata[KEY_W +: IDX_W];
                    left_next = left_init;
                    res_loc_next  = '0;
                    res_slot_next = '0;
                    if (left_init == '0)
                    begin
                        res_st_next = STATUS_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    state_next = S_DONE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        if (rd_entry.valid)
                        begin
                            res_st_next   = STATUS_FOUND;
                            res_loc_next  = rd_entry.location;
                            res_slot_next = rd_entry.slot;
                        end
                        else
                        begin
                            res_st_next = STATUS_MISSING;
                        end
                    end
                    else if (rd_entry.valid && rd_entry.slot > slot_reg)
                    begin
                        res_st_next   = STATUS_DROPPED;
                        res_slot_next = rd_entry.slot;
                    end
                    else
                    begin
                        // Write the item back into the entry
                        wr_en             = 1'b1;
                        wr_entry.valid    = 1'b1;
                        wr_entry.key      = key_reg;
                        wr_entry.memo     = memo_reg;
                        wr_entry.slot     = slot_reg;
                        wr_entry.location = loc_reg;
                        if (rd_entry.valid)
                        begin
                            res_st_next   = STATUS_REPLACED;
                            res_slot_next = rd_entry.slot;
                        end
                        else
                        begin
                            res_st_next = STATUS_INSERTED;
                        end
                    end
                end
                else
                begin
                    // Advance to the next entry, wrapping at the end
                    idx_next  = idx_reg + 1'b1;
                    left_next = left_reg - CNT_ONE;
                    if (left_reg == CNT_ONE)
                    begin
                        res_st_next = STATUS_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_st_reg;
                    m_data_next  = {res_slot_reg, res_loc_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            limit_reg   <= LIMIT_RESET;
            idx_reg     <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            idx_reg     <= idx_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        memo_reg     <= memo_next;
        slot_reg     <= slot_next;
        loc_reg      <= loc_next;
        res_st_reg   <= res_st_next;
        res_loc_reg  <= res_loc_next;
        res_slot_reg <= res_slot_next;
        m_user_reg   <= m_user_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire
